@@ hdl/bba_pkg.sv @@
// Package of the buddy block allocator: payload types, status codes,
// controller commands and the status returned by the datapath. No dependencies.
`default_nettype none
package bba_pkg;

  localparam int SIZE_W = 32;
  localparam int OFF_W  = 31;
  localparam int CFG_W  = 5;
  localparam int ORD_W  = 6;

  localparam logic [CFG_W-1:0] RST_LO_ORD = 5'd0;
  localparam logic [CFG_W-1:0] RST_HI_ORD = 5'd7;

  localparam logic CFG_LO_ORD = 1'b0;
  localparam logic CFG_HI_ORD = 1'b1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO       = 3'd1,
    ST_TOO_BIG    = 3'd2,
    ST_EXHAUSTED  = 3'd3,
    ST_BAD_CONFIG = 3'd4,
    ST_BAD_FREE   = 3'd5
  } status_e;

  typedef struct packed {
    logic              command;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  block_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [OFF_W-1:0] result_offset;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_ORD_STEP,
    OP_ALLOC_SETUP,
    OP_FREE_SETUP,
    OP_LVL_INC,
    OP_POP,
    OP_TAKE,
    OP_SPLIT,
    OP_SRCH_START,
    OP_SRCH_NEXT,
    OP_MOVE_RD,
    OP_MOVE_WR,
    OP_MERGE,
    OP_PUSH,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e code;
  } ctl_cmd_t;

  typedef struct packed {
    logic init_pending;
    logic cfg_good;
    logic is_free;
    logic size_zero;
    logic ord_more;
    logic need_big;
    logic free_bad;
    logic lvl_gt_top;
    logic lvl_lt_top;
    logic fill_zero;
    logic split_more;
    logic match;
    logic ptr_zero;
    logic move_more;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ hdl/bba_chan_if.sv @@
// Valid/ready channel interface of the buddy block allocator.
// Carries a payload type given as a parameter; no other dependencies.
`default_nettype none
interface bba_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/bba_ctrl.sv @@
// Controller state machine of the buddy block allocator.
// Uses bba_pkg; drives commands into bba_dp and reads its status.
`default_nettype none
module bba_ctrl import bba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  dp_stat_t stat_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ORD, S_CHK, S_ASRCH, S_AWAIT, S_ASPLIT,
    S_FLVL, S_FCMP, S_FMOVE, S_FMCHK, S_FPUSH, S_FIN
  } state_e;

  state_e  state_q, state_d;
  status_e code_q, code_d;

  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    cmd_o.op    = OP_NONE;
    cmd_o.code  = code_q;
    req_ready_o = (state_q == S_IDLE) && !stat_i.init_pending;
    unique case (state_q)
      S_IDLE: begin
        if (stat_i.init_pending) begin
          cmd_o.op = OP_INIT;
        end else if (req_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_ORD;
        end
      end
      S_ORD: begin
        if (stat_i.ord_more) begin
          cmd_o.op = OP_ORD_STEP;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (!stat_i.cfg_good) begin
          code_d  = ST_BAD_CONFIG;
          state_d = S_FIN;
        end else if (stat_i.is_free) begin
          if (stat_i.free_bad) begin
            code_d  = ST_BAD_FREE;
            state_d = S_FIN;
          end else begin
            cmd_o.op = OP_FREE_SETUP;
            state_d  = S_FLVL;
          end
        end else if (stat_i.size_zero) begin
          code_d  = ST_ZERO;
          state_d = S_FIN;
        end else if (stat_i.need_big) begin
          code_d  = ST_TOO_BIG;
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_ALLOC_SETUP;
          state_d  = S_ASRCH;
        end
      end
      S_ASRCH: begin
        if (stat_i.lvl_gt_top) begin
          code_d  = ST_EXHAUSTED;
          state_d = S_FIN;
        end else if (stat_i.fill_zero) begin
          cmd_o.op = OP_LVL_INC;
        end else begin
          cmd_o.op = OP_POP;
          state_d  = S_AWAIT;
        end
      end
      S_AWAIT: begin
        cmd_o.op = OP_TAKE;
        state_d  = S_ASPLIT;
      end
      S_ASPLIT: begin
        if (stat_i.split_more) begin
          cmd_o.op = OP_SPLIT;
        end else begin
          code_d  = ST_OK;
          state_d = S_FIN;
        end
      end
      S_FLVL: begin
        if (stat_i.lvl_lt_top && !stat_i.fill_zero) begin
          cmd_o.op = OP_SRCH_START;
          state_d  = S_FCMP;
        end else begin
          state_d = S_FPUSH;
        end
      end
      S_FCMP: begin
        if (stat_i.match) begin
          if (stat_i.move_more) begin
            cmd_o.op = OP_MOVE_RD;
            state_d  = S_FMOVE;
          end else begin
            cmd_o.op = OP_MERGE;
            state_d  = S_FLVL;
          end
        end else if (stat_i.ptr_zero) begin
          state_d = S_FPUSH;
        end else begin
          cmd_o.op = OP_SRCH_NEXT;
        end
      end
      S_FMOVE: begin
        cmd_o.op = OP_MOVE_WR;
        state_d  = S_FMCHK;
      end
      S_FMCHK: begin
        if (stat_i.move_more) begin
          cmd_o.op = OP_MOVE_RD;
          state_d  = S_FMOVE;
        end else begin
          cmd_o.op = OP_MERGE;
          state_d  = S_FLVL;
        end
      end
      S_FPUSH: begin
        cmd_o.op = OP_PUSH;
        code_d   = ST_OK;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  a_init_blocks_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_LOAD) |-> !stat_i.init_pending)
    else $error("transaction accepted before the free state was restored");
  a_finish_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_FINISH) |-> !stat_i.out_busy)
    else $error("result overwrites a pending transaction");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_POP) |-> (!stat_i.fill_zero && !stat_i.lvl_gt_top))
    else $error("pop from an empty free stack");

endmodule
`default_nettype wire

@@ hdl/bba_dp.sv @@
// Datapath of the buddy block allocator: configuration, stack fill counts,
// free stack memory, request and result registers. Uses bba_pkg.
`default_nettype none
module bba_dp import bba_pkg::*; #(
  parameter int LEVELS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  req_t             req_data_i,
  input  ctl_cmd_t         cmd_i,
  output dp_stat_t         stat_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output rsp_t             rsp_data_o
);

  localparam int SD    = 1 << (LEVELS - 1);
  localparam int PW    = (LEVELS > 1) ? LEVELS - 1 : 1;
  localparam int IW    = PW;
  localparam int FW    = LEVELS;
  localparam int LIW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LVW   = $clog2(LEVELS + 1);
  localparam int AW    = LIW + PW;
  localparam int DEPTH = 1 << AW;
  localparam logic [FW-1:0]    SD_C     = FW'(SD);
  localparam logic [ORD_W-1:0] LEVELS_C = ORD_W'(LEVELS);
  localparam bit RST_GOOD = (int'(RST_HI_ORD) - int'(RST_LO_ORD)) < LEVELS;
  localparam int RST_TOP  = int'(RST_HI_ORD) - int'(RST_LO_ORD);

  logic [CFG_W-1:0] min_q, min_d, max_q, max_d;
  logic [FW-1:0]    fill_q [LEVELS];
  logic [FW-1:0]    fill_d [LEVELS];
  logic             init_q, init_d;
  logic             rsp_valid_q, rsp_valid_d;

  logic              cmd_q;
  logic [SIZE_W-1:0] size_q;
  logic [OFF_W-1:0]  off_q;
  logic [ORD_W-1:0]  ord_q;
  logic [LVW-1:0]    lvl_q, need_q;
  logic [IW-1:0]     idx_q;
  logic [FW-1:0]    ptr_q;
  logic [IW-1:0]     rdata_q;
  status_e           rsp_status_q;
  logic [OFF_W-1:0]  rsp_off_q;

  logic [IW-1:0] mem [DEPTH];

  logic [CFG_W-1:0] top, ntop;
  logic             cfg_good, ngood;
  logic [LIW-1:0]   li, lim1;
  logic [LVW-1:0]   lm1, lvl_new;
  logic [FW-1:0]    fill_cur, fill_m1, ptr_m1, ptr_p1;
  logic [IW-1:0]    bit_cur, bit_dn;
  logic [SIZE_W:0]  ord_pow, ord_mask;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [IW-1:0] wdata;

  assign top      = max_q - min_q;
  assign cfg_good = (min_q <= max_q) && (ORD_W'(top) < LEVELS_C);
  assign li       = lvl_q[LIW-1:0];
  assign lm1      = lvl_q - LVW'(1);
  assign lim1     = lm1[LIW-1:0];
  assign fill_cur = fill_q[li];
  assign fill_m1  = fill_cur - FW'(1);
  assign ptr_m1   = ptr_q - FW'(1);
  assign ptr_p1   = ptr_q + FW'(1);
  assign bit_cur  = IW'(1) << lvl_q;
  assign bit_dn   = IW'(1) << lm1;
  assign ord_pow  = (SIZE_W + 1)'(1) << ord_q;
  assign ord_mask = ord_pow - (SIZE_W + 1)'(1);
  assign lvl_new  = LVW'(ord_q - ORD_W'(min_q));

  always_comb begin
    stat_o.init_pending = init_q;
    stat_o.cfg_good     = cfg_good;
    stat_o.is_free      = (cmd_q == CMD_FREE);
    stat_o.size_zero    = (size_q == '0);
    stat_o.ord_more     = (ord_q < ORD_W'(SIZE_W)) && ({1'b0, size_q} > ord_pow);
    stat_o.need_big     = ord_q > ORD_W'(max_q);
    stat_o.free_bad     = stat_o.need_big || ((off_q >> max_q) != '0) ||
                          ((off_q & ord_mask[OFF_W-1:0]) != '0);
    stat_o.lvl_gt_top   = ORD_W'(lvl_q) > ORD_W'(top);
    stat_o.lvl_lt_top   = ORD_W'(lvl_q) < ORD_W'(top);
    stat_o.fill_zero    = (fill_cur == '0);
    stat_o.split_more   = lvl_q > need_q;
    stat_o.match        = (rdata_q == (idx_q ^ bit_cur));
    stat_o.ptr_zero     = (ptr_q == '0);
    stat_o.move_more    = ({1'b0, ptr_q} + (FW + 1)'(1)) < {1'b0, fill_cur};
    stat_o.out_busy     = rsp_valid_q && !rsp_ready_i;
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = '0;
    case (cmd_i.op)
      OP_INIT: begin
        we    = 1'b1;
        waddr = {top[LIW-1:0], PW'(0)};
      end
      OP_POP, OP_SRCH_START: begin
        re    = 1'b1;
        raddr = {li, fill_m1[PW-1:0]};
      end
      OP_SRCH_NEXT: begin
        re    = 1'b1;
        raddr = {li, ptr_m1[PW-1:0]};
      end
      OP_MOVE_RD: begin
        re    = 1'b1;
        raddr = {li, ptr_p1[PW-1:0]};
      end
      OP_MOVE_WR: begin
        we    = 1'b1;
        waddr = {li, ptr_q[PW-1:0]};
        wdata = rdata_q;
      end
      OP_SPLIT: begin
        we    = fill_q[lim1] < SD_C;
        waddr = {lim1, fill_q[lim1][PW-1:0]};
        wdata = idx_q + bit_dn;
      end
      OP_PUSH: begin
        we    = fill_cur < SD_C;
        waddr = {li, fill_cur[PW-1:0]};
        wdata = idx_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    min_d  = min_q;
    max_d  = max_q;
    fill_d = fill_q;
    init_d = init_q;
    ntop   = '0;
    ngood  = 1'b0;
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_LO_ORD) begin
        min_d = cfg_data_i;
      end else begin
        max_d = cfg_data_i;
      end
      ntop  = max_d - min_d;
      ngood = (min_d <= max_d) && (ORD_W'(ntop) < LEVELS_C);
      for (int l = 0; l < LEVELS; l++) begin
        fill_d[l] = (ngood && (ORD_W'(ntop) == ORD_W'(l))) ? FW'(1) : '0;
      end
      init_d = 1'b1;
    end else begin
      case (cmd_i.op)
        OP_INIT:           init_d = 1'b0;
        OP_POP, OP_MERGE:  fill_d[li] = fill_m1;
        OP_SPLIT: begin
          if (fill_q[lim1] < SD_C) begin
            fill_d[lim1] = fill_q[lim1] + FW'(1);
          end
        end
        OP_PUSH: begin
          if (fill_cur < SD_C) begin
            fill_d[li] = fill_cur + FW'(1);
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.op == OP_FINISH) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= RST_LO_ORD;
      max_q       <= RST_HI_ORD;
      init_q      <= 1'b1;
      rsp_valid_q <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        fill_q[l] <= (RST_GOOD && (l == RST_TOP)) ? FW'(1) : '0;
      end
    end else begin
      min_q       <= min_d;
      max_q       <= max_d;
      init_q      <= init_d;
      rsp_valid_q <= rsp_valid_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cmd_q  <= req_data_i.command;
        size_q <= req_data_i.request_size;
        off_q  <= req_data_i.block_offset;
        ord_q  <= ORD_W'(min_q);
      end
      OP_ORD_STEP:    ord_q <= ord_q + ORD_W'(1);
      OP_ALLOC_SETUP: begin
        lvl_q  <= lvl_new;
        need_q <= lvl_new;
      end
      OP_FREE_SETUP: begin
        lvl_q <= lvl_new;
        idx_q <= IW'(off_q >> min_q);
      end
      OP_LVL_INC:     lvl_q <= lvl_q + LVW'(1);
      OP_TAKE:        idx_q <= rdata_q;
      OP_SPLIT:       lvl_q <= lm1;
      OP_SRCH_START:  ptr_q <= fill_m1;
      OP_SRCH_NEXT:   ptr_q <= ptr_m1;
      OP_MOVE_WR:     ptr_q <= ptr_p1;
      OP_MERGE: begin
        idx_q <= idx_q & ~bit_cur;
        lvl_q <= lvl_q + LVW'(1);
      end
      OP_FINISH: begin
        rsp_status_q <= cmd_i.code;
        rsp_off_q    <= ((cmd_i.code == ST_OK) && (cmd_q == CMD_ALLOC)) ?
                        (OFF_W'(idx_q) << min_q) : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign rsp_valid_o              = rsp_valid_q;
  assign rsp_data_o.status        = rsp_status_q;
  assign rsp_data_o.result_offset = rsp_off_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat_o.lvl_gt_top |-> (fill_cur <= SD_C))
    else $error("free stack fill count above its depth");
  a_merge_keeps_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_MERGE) |-> stat_o.lvl_lt_top)
    else $error("merge attempted at the top order");
  a_rsp_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FINISH) |=> rsp_valid_q)
    else $error("finished transaction not presented");

endmodule
`default_nettype wire

@@ hdl/buddy_block_allocator.sv @@
// Top level of the buddy block allocator: joins bba_ctrl and bba_dp.
// Uses bba_pkg and the bba_chan_if channel interface.
//
//  Channel   Direction  Payload
//  req_i     in         command, request_size, block_offset
//  rsp_o     out        status, result_offset
//  cfg_*_i   in         write of the smallest order (index 0) or the region order (index 1)
//
// One transaction at a time. An allocate walks the orders for the size rounding
// (one a cycle), searches the stack levels and then performs the splits.
// A free scans stack entries for a buddy and shifts entries down on
// removal, so its time depends on the stack contents.
// After reset and after each configuration write the region block is restored
// before a request is accepted. A waiting result does not block accept.
`default_nettype none
module buddy_block_allocator import bba_pkg::*; #(
  parameter int LEVELS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  bba_chan_if.sink         req_i,
  bba_chan_if.source       rsp_o
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bba_dp #(.LEVELS(LEVELS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_data_i  (req_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_data_o  (rsp_o.data)
  );

endmodule
`default_nettype wire

@@ bench/buddy_block_allocator_tb.sv @@
// Testbench of the buddy block allocator: drives requests and configuration
// writes, predicts every response with a behavioral buddy model and checks it.
// Depends on bba_pkg, bba_chan_if and the buddy_block_allocator RTL.
`timescale 1ns / 100ps

class alloc_scoreboard;
  localparam int LV = 8;
  localparam int DEPTH = 1 << (LV - 1);

  bit [4:0] min_ord;
  bit [4:0] max_ord;
  bit [15:0] free_idx [LV][DEPTH];
  int unsigned fill [LV];
  bba_pkg::rsp_t pending_rsp [$];
  int unsigned errors;

  function new();
    min_ord = bba_pkg::RST_LO_ORD;
    max_ord = bba_pkg::RST_HI_ORD;
    errors = 0;
    restore();
  endfunction

  function bit cfg_good();
    return min_ord <= max_ord && (max_ord - min_ord) < LV;
  endfunction

  function void restore();
    foreach (fill[l]) fill[l] = 0;
    if (cfg_good()) begin
      free_idx[max_ord - min_ord][0] = 0;
      fill[max_ord - min_ord] = 1;
    end
  endfunction

  function void write_cfg(logic idx, bit [4:0] val);
    if (idx == bba_pkg::CFG_LO_ORD) min_ord = val;
    else max_ord = val;
    restore();
  endfunction

  function void push_blk(int unsigned lvl, bit [31:0] idx);
    if (lvl >= LV || fill[lvl] >= DEPTH) return;
    free_idx[lvl][fill[lvl]] = idx[15:0];
    fill[lvl]++;
  endfunction

  function bit take_free(int unsigned lvl, bit [31:0] idx);
    int unsigned n;
    n = fill[lvl];
    for (int unsigned i = n; i > 0; i--) begin
      if (free_idx[lvl][i-1] == idx[15:0]) begin
        for (int unsigned j = i - 1; j + 1 < n; j++) free_idx[lvl][j] = free_idx[lvl][j+1];
        fill[lvl] = n - 1;
        return 1;
      end
    end
    return 0;
  endfunction

  function int unsigned order_for(bit [31:0] size);
    int unsigned o;
    o = min_ord;
    while (o < 40 && (64'd1 << o) < {32'd0, size}) o++;
    return o;
  endfunction

  function void note_request(bba_pkg::req_t r);
    bba_pkg::rsp_t p;
    int unsigned need, lvl, top;
    bit [31:0] idx, b;
    bit [63:0] off;
    p.status = bba_pkg::ST_OK;
    p.result_offset = '0;
    off = {33'd0, r.block_offset};
    if (!cfg_good()) begin
      p.status = bba_pkg::ST_BAD_CONFIG;
    end else if (r.command == bba_pkg::CMD_ALLOC) begin
      if (r.request_size == 0) begin
        p.status = bba_pkg::ST_ZERO;
      end else begin
        need = order_for(r.request_size);
        if (need > max_ord) begin
          p.status = bba_pkg::ST_TOO_BIG;
        end else begin
          top = max_ord - min_ord;
          lvl = need - min_ord;
          while (lvl <= top && fill[lvl] == 0) lvl++;
          if (lvl > top) begin
            p.status = bba_pkg::ST_EXHAUSTED;
          end else begin
            fill[lvl]--;
            idx = free_idx[lvl][fill[lvl]];
            while (lvl > need - min_ord) begin
              lvl--;
              push_blk(lvl, idx + (32'd1 << lvl));
            end
            p.result_offset = 31'(64'(idx) << min_ord);
          end
        end
      end
    end else begin
      need = order_for(r.request_size);
      if (need > max_ord || (off >> max_ord) != 0 ||
          (off & ((64'd1 << need) - 1)) != 0) begin
        p.status = bba_pkg::ST_BAD_FREE;
      end else begin
        top = max_ord - min_ord;
        lvl = need - min_ord;
        idx = 32'(off >> min_ord);
        while (lvl < top) begin
          b = 32'd1 << lvl;
          if (!take_free(lvl, idx ^ b)) break;
          idx &= ~b;
          lvl++;
        end
        push_blk(lvl, idx);
      end
    end
    pending_rsp.push_back(p);
  endfunction

  task report(string what);
    $display("response error: %s", what);
    errors++;
  endtask

  task check_response(bba_pkg::rsp_t got);
    bba_pkg::rsp_t want;
    if (pending_rsp.size() == 0) begin
      report($sformatf("unexpected response %p", got));
      return;
    end
    want = pending_rsp.pop_front();
    if (got.status !== want.status)
      report($sformatf("status %0d, predicted %0d", got.status, want.status));
    if (got.result_offset !== want.result_offset)
      report($sformatf("offset %0h, predicted %0h", got.result_offset, want.result_offset));
  endtask
endclass

module buddy_block_allocator_tb;
  import bba_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;
  bit [30:0] held [$];

  bba_chan_if #(.payload_t(req_t)) req_ch ();
  bba_chan_if #(.payload_t(rsp_t)) rsp_ch ();

  alloc_scoreboard sb = new();

  buddy_block_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req_i(req_ch), .rsp_o(rsp_ch)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
    if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WATCHDOG) begin
      $display("buddy_block_allocator: mismatch");
      $finish;
    end
  end

  task automatic send_request(logic cmd, logic [31:0] size, logic [30:0] off);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= '{command: cmd, request_size: size, block_offset: off};
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_cfg(idx, val);
    cfg_we_i <= 1'b0;
    held.delete();
    @(posedge clk_i);
  endtask

  task automatic set_cfg(logic [4:0] lo, logic [4:0] hi);
    write_reg(CFG_LO_ORD, lo);
    write_reg(CFG_HI_ORD, hi);
  endtask

  task automatic random_request();
    int k;
    bit [31:0] sz;
    int span;
    int unsigned pick;
    span = sb.max_ord;
    k = $urandom_range(99);
    sz = 32'd1 << $urandom_range(span);
    if ($urandom_range(1)) sz = sz - $urandom_range(sz >> 1);
    if (k < 45) begin
      send_request(CMD_ALLOC, sz, 31'($urandom));
    end else if (k < 85 && held.size() != 0) begin
      pick = $urandom_range(held.size() - 1);
      send_request(CMD_FREE, sz & 32'h1, held[pick]);
      held.delete(pick);
    end else if (k < 93) begin
      send_request(CMD_FREE, sz, 31'($urandom) & ((31'd1 << span) - 1) & ~((31'(sz) << 1) - 1));
    end else begin
      send_request(1'($urandom_range(1)), $urandom, 31'($urandom));
    end
  endtask

  always @(posedge clk_i) begin
    if (rsp_ch.valid && rsp_ch.ready && rsp_ch.data.status == ST_OK &&
        rsp_ch.data.result_offset != 0 && held.size() < 64)
      held.push_back(rsp_ch.data.result_offset);
  end

  initial begin
    logic [4:0] cfgs [8][2];
    cfgs = '{'{0, 7}, '{3, 9}, '{0, 0}, '{24, 31}, '{31, 31}, '{5, 2},
             '{0, 31}, '{2, 6}};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = 1'b0;
    cfg_data_i = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_request(CMD_ALLOC, 0, 0);
    send_request(CMD_ALLOC, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_request(CMD_ALLOC, 1, 0);
    send_request(CMD_ALLOC, 3, 0);
    send_request(CMD_ALLOC, 128, 0);
    send_request(CMD_FREE, 1, 0);
    send_request(CMD_FREE, 4, 4);
    send_request(CMD_FREE, 4, 2);
    send_request(CMD_FREE, 0, 1);
    send_request(CMD_FREE, 256, 0);
    send_request(CMD_FREE, 1, 31'h7FFF_FFFF);
    send_request(CMD_FREE, 1, 128);
    send_request(CMD_ALLOC, 128, 0);
    send_request(CMD_ALLOC, 128, 0);
    send_request(CMD_FREE, 128, 0);
    send_request(CMD_FREE, 128, 0);
    for (int i = 0; i < 130; i++) send_request(CMD_FREE, 1, 0);
    write_reg(CFG_LO_ORD, 9);
    send_request(CMD_ALLOC, 5, 0);
    send_request(CMD_FREE, 5, 0);

    for (int ph = 0; ph < 8; ph++) begin
      set_cfg(cfgs[ph][0], cfgs[ph][1]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 80; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 80; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      for (int i = 0; i < 206; i++) random_request();
    end

    drain();
    if (sb.errors == 0 && sb.pending_rsp.size() == 0)
      $display("buddy_block_allocator: match");
    else
      $display("buddy_block_allocator: mismatch");
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/bba_pkg.sv
hdl/bba_chan_if.sv
hdl/bba_ctrl.sv
hdl/bba_dp.sv
hdl/buddy_block_allocator.sv
bench/buddy_block_allocator_tb.sv
